[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/rla_pkg.sv]
// ----------------------------------------------------------------------------
// rla_pkg
// Shared types, constants and digit helpers of the radix literal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package rla_pkg;

  localparam int unsigned LitW     = 256;             // accumulator width
  localparam int unsigned WordW    = 64;              // output slice width
  localparam int unsigned NumWords = LitW / WordW;    // slices per literal
  localparam int unsigned IdxW     = $clog2(NumWords);
  localparam int unsigned CwW      = $clog2(LitW) + 1; // clamped width 1..LitW

  localparam logic [7:0] CharUnderscore = 8'h5F;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_BIN = 2'd2,
    BASE_OCT = 2'd3
  } base_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_DIGIT = 2'd1,
    ST_NO_DIGITS = 2'd2
  } status_e;

  // Finished literal handed to the word emitter.
  typedef struct packed {
    logic [LitW-1:0] value;     // already masked, zero on error
    logic [IdxW-1:0] last_idx;  // index of the final slice
    status_e         status;
  } load_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // ASCII hex digit decode, either case.
  function automatic digit_t decode_digit(input logic [7:0] ch);
    digit_t r;
    r.valid = 1'b1;
    r.value = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r.value = 4'(ch - 8'h30);
    end else if (ch >= 8'h61 && ch <= 8'h66) begin
      r.value = 4'(ch - 8'h57);
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      r.value = 4'(ch - 8'h37);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [4:0] radix_of(input base_e b);
    logic [4:0] r;
    case (b)
      BASE_DEC: r = 5'd10;
      BASE_HEX: r = 5'd16;
      BASE_BIN: r = 5'd2;
      BASE_OCT: r = 5'd8;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/rla_word_emitter.sv]
// ----------------------------------------------------------------------------
// rla_word_emitter
// Holds one finished literal and streams it out as 64-bit slices.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rla_word_emitter (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_valid_i,
  output logic                 load_ready_o,
  input  wire rla_pkg::load_t  load_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  output logic [71:0]          m_axis_tdata_o,  // [63:0] value_word, [65:64] word_index
  output logic                 m_axis_tlast_o,  // last_word
  output logic [1:0]           m_axis_tuser_o   // [1:0] status
);

  logic                      busy_q, busy_d;
  logic [rla_pkg::IdxW-1:0]  idx_q, idx_d;
  rla_pkg::load_t            buf_q;
  logic                      take;
  logic                      load;

  assign take         = busy_q && m_axis_tready_i;
  assign load_ready_o = !busy_q || (take && m_axis_tlast_o);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (take) begin
      if (m_axis_tlast_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= load_i;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tlast_o  = (idx_q == buf_q.last_idx);
  assign m_axis_tuser_o  = buf_q.status;
  assign m_axis_tdata_o  = {6'd0, idx_q,
                            buf_q.value[{idx_q, 6'd0} +: rla_pkg::WordW]};

  `ASSERT_CLK(a_idx_in_range, clk_i, rst_ni,
    busy_q |-> idx_q <= buf_q.last_idx, "slice index ran past the final slice")
  `ASSERT_CLK(a_err_single, clk_i, rst_ni,
    busy_q && buf_q.status != rla_pkg::ST_OK |-> m_axis_tlast_o && idx_q == '0,
    "error result is not a single final request")
  `ASSERT_CLK(a_load_starts, clk_i, rst_ni,
    load |=> busy_q && idx_q == '0, "new literal does not start at slice zero")

endmodule

`default_nettype wire

[sv/radix_literal_accumulator.sv]
// A character is registered, then folded into the accumulator; a final one goes
//   masked into the emitter's slice buffer. Throughput: one character per cycle;
//   a literal's results leave at one slice per cycle while the sink is ready
//   (1 to 4 requests), and its last character waits only if the previous one is
//   still being sent. Reset clears the accumulator, flags and all valids at once.
// ----------------------------------------------------------------------------
// radix_literal_accumulator
// ASCII digit string to integer, decimal/hex/binary/octal, up to 256 bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module radix_literal_accumulator (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Character stream in
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [23:0] s_axis_tdata_i,   // [7:0] character, [16:8] target_width
  input  wire         s_axis_tlast_i,   // last_char
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] base_sel
  // Value slices out
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] value_word, [65:64] word_index
  output logic        m_axis_tlast_o,   // last_word
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned LitW = rla_pkg::LitW;
  localparam int unsigned CwW  = rla_pkg::CwW;

  // --------------------------------------------------------------------------
  // Input register. Holds one character until the accumulator takes it.
  // --------------------------------------------------------------------------
  logic              in_valid_q;
  logic [7:0]        in_char_q;
  rla_pkg::base_e    in_base_q;
  logic [8:0]        in_width_q;
  logic              in_last_q;

  logic              advance;      // input register moves into the accumulator
  logic              s_accept;
  logic              load_ready;

  // A non-final character never waits; a final one needs the emitter free.
  assign advance         = in_valid_q && (!in_last_q || load_ready);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q  <= s_axis_tdata_i[7:0];
      in_width_q <= s_axis_tdata_i[16:8];
      in_base_q  <= rla_pkg::base_e'(s_axis_tuser_i);
      in_last_q  <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulator: value = value * base + digit, modulo 2^LitW.
  // Radix 2/8/16 are pure shifts with the digit OR-ed in; decimal is
  // x*8 + x*2 + d, the only wide adder.
  // --------------------------------------------------------------------------
  logic [LitW-1:0]   acc_q, acc_d;
  logic              saw_q, saw_d;
  logic              bad_q, bad_d;

  rla_pkg::digit_t   dig;
  logic              is_skip;
  logic              dig_ok;
  logic [LitW-1:0]   acc_step;
  logic [LitW-1:0]   dig_ext;

  // Literal outcome after this character
  logic [LitW-1:0]   acc_fin;
  logic              saw_fin;
  logic              bad_fin;

  assign dig     = rla_pkg::decode_digit(in_char_q);
  assign is_skip = (in_char_q == rla_pkg::CharUnderscore);
  assign dig_ok  = dig.valid && ({1'b0, dig.value} < rla_pkg::radix_of(in_base_q));
  assign dig_ext = {{(LitW-4){1'b0}}, dig.value};

  always_comb begin
    case (in_base_q)
      rla_pkg::BASE_DEC: acc_step = (acc_q << 3) + (acc_q << 1) + dig_ext;
      rla_pkg::BASE_HEX: acc_step = (acc_q << 4) | dig_ext;
      rla_pkg::BASE_BIN: acc_step = (acc_q << 1) | dig_ext;
      rla_pkg::BASE_OCT: acc_step = (acc_q << 3) | dig_ext;
      default:           acc_step = acc_q;
    endcase
  end

  // Once a bad character is seen, the literal is frozen until its end.
  always_comb begin
    acc_fin = acc_q;
    saw_fin = saw_q;
    bad_fin = bad_q;
    if (!is_skip && !bad_q) begin
      if (dig_ok) begin
        acc_fin = acc_step;
        saw_fin = 1'b1;
      end else begin
        bad_fin = 1'b1;
      end
    end
  end

  always_comb begin
    acc_d = acc_q;
    saw_d = saw_q;
    bad_d = bad_q;
    if (advance) begin
      if (in_last_q) begin
        // Literal handed off; start the next one clean.
        acc_d = '0;
        saw_d = 1'b0;
        bad_d = 1'b0;
      end else begin
        acc_d = acc_fin;
        saw_d = saw_fin;
        bad_d = bad_fin;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      saw_q <= 1'b0;
      bad_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      saw_q <= saw_d;
      bad_q <= bad_d;
    end
  end

  // --------------------------------------------------------------------------
  // Final character: clamp width to 1..LitW, mask, pick slice count or error.
  // --------------------------------------------------------------------------
  logic [CwW-1:0]    cw;
  logic [CwW-1:0]    cw_m1;
  logic [LitW-1:0]   width_mask;
  rla_pkg::load_t    load;

  always_comb begin
    if (in_width_q == '0) begin
      cw = CwW'(1);
    end else if (in_width_q > 9'(LitW)) begin
      cw = CwW'(LitW);
    end else begin
      cw = CwW'(in_width_q);
    end
  end

  assign cw_m1      = cw - 1'b1;
  // A shift by the full width leaves zero, so the mask is then all ones.
  assign width_mask = ~({LitW{1'b1}} << cw);

  always_comb begin
    load.value    = acc_fin & width_mask;
    load.last_idx = cw_m1[CwW-2 -: rla_pkg::IdxW];
    load.status   = rla_pkg::ST_OK;
    if (bad_fin || !saw_fin) begin
      load.value    = '0;
      load.last_idx = '0;
      load.status   = bad_fin ? rla_pkg::ST_BAD_DIGIT : rla_pkg::ST_NO_DIGITS;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: one request per 64-bit slice, lowest first.
  // --------------------------------------------------------------------------
  rla_word_emitter u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_valid_i    (in_valid_q && in_last_q),
    .load_ready_o    (load_ready),
    .load_i          (load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  `ASSERT_CLK(a_clear_after_last, clk_i, rst_ni,
    advance && in_last_q |=> acc_q == '0 && !saw_q && !bad_q,
    "state not cleared after the final character")
  `ASSERT_CLK(a_frozen_on_bad, clk_i, rst_ni,
    bad_q && !(advance && in_last_q) |=> acc_q == $past(acc_q),
    "accumulator moved after a bad character")

endmodule

`default_nettype wire

[tb/sv/rla_slice_checker.sv]
// ----------------------------------------------------------------------------
// rla_slice_checker
// Watches both streams of the radix literal accumulator, folds every accepted
// character into its own copy of the accumulator, queues the value slices or
// the error result that each final character must produce, and compares every
// accepted output request against the oldest queued slice.
// ----------------------------------------------------------------------------
module rla_slice_checker
  import rla_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_tvalid_i,
  input  wire         s_tready_i,
  input  wire  [23:0] s_tdata_i,   // [7:0] character, [16:8] target_width
  input  wire         s_tlast_i,   // last_char
  input  wire  [1:0]  s_tuser_i,   // [1:0] base_sel
  input  wire         m_tvalid_i,
  input  wire         m_tready_i,
  input  wire  [71:0] m_tdata_i,   // [63:0] value_word, [65:64] word_index
  input  wire         m_tlast_i,   // last_word
  input  wire  [1:0]  m_tuser_i,   // [1:0] status
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WordW-1:0] word;
    logic [IdxW-1:0]  idx;
    logic             last;
    status_e          status;
  } slice_t;

  slice_t          slices_due[$];
  logic [LitW-1:0] lit_value;
  bit              seen_digit;
  bit              seen_bad;
  int              n_fail;

  // -1 for anything that is not a hex digit of either case
  function automatic int ascii_digit(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
    if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
    if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
    return -1;
  endfunction

  function automatic int radix_value(input base_e b);
    case (b)
      BASE_HEX: return 16;
      BASE_BIN: return 2;
      BASE_OCT: return 8;
      default:  return 10;
    endcase
  endfunction

  // One character: update the literal, and on the final one queue its slices.
  task automatic fold_char(input logic [7:0] ch, input base_e b, input logic [8:0] w,
                           input logic last);
    int              d;
    int              r;
    int unsigned     width;
    int unsigned     n_words;
    logic [LitW-1:0] masked;
    slice_t          s;
    r = radix_value(b);
    if (ch != CharUnderscore && !seen_bad) begin
      d = ascii_digit(ch);
      if (d < 0 || d >= r) begin
        seen_bad = 1'b1;
      end else begin
        seen_digit = 1'b1;
        lit_value  = lit_value * LitW'(r) + LitW'(d);
      end
    end
    if (!last) return;
    if (seen_bad || !seen_digit) begin
      s.word   = '0;
      s.idx    = '0;
      s.last   = 1'b1;
      s.status = seen_bad ? ST_BAD_DIGIT : ST_NO_DIGITS;  // bad digit wins
      slices_due.insert(slices_due.size(), s);
    end else begin
      width = w;
      if (width == 0) width = 1;
      if (width > LitW) width = LitW;
      n_words = (width + WordW - 1) / WordW;
      masked  = lit_value & ({LitW{1'b1}} >> (LitW - width));
      for (int unsigned k = 0; k < n_words; k++) begin
        s.word   = masked[k*WordW +: WordW];
        s.idx    = IdxW'(k);
        s.last   = (k == n_words - 1);
        s.status = ST_OK;
        slices_due.insert(slices_due.size(), s);
      end
    end
    lit_value  = '0;
    seen_digit = 1'b0;
    seen_bad   = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slice_t s;
    if (!rst_ni) begin
      slices_due.delete();
      lit_value  = '0;
      seen_digit = 1'b0;
      seen_bad   = 1'b0;
      n_fail     = 0;
    end else begin
      // compare first: a slice leaving now never stems from a character arriving now
      if (m_tvalid_i && m_tready_i) begin
        if (slices_due.size() == 0) begin
          $error("slice request with no slice expected: word %0h", m_tdata_i[63:0]);
          n_fail++;
        end else begin
          s = slices_due.pop_front();
          check_field("value_word", s.word, m_tdata_i[63:0]);
          check_field("word_index", 64'(s.idx), 64'(m_tdata_i[65:64]));
          check_field("last_word", 64'(s.last), 64'(m_tlast_i));
          check_field("status", 64'(s.status), 64'(m_tuser_i));
        end
      end
      if (s_tvalid_i && s_tready_i)
        fold_char(s_tdata_i[7:0], base_e'(s_tuser_i), s_tdata_i[16:8], s_tlast_i);
    end
    fail_count_o <= n_fail;
    pending_o    <= slices_due.size();
  end

endmodule

[tb/sv/tb_radix_literal_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_radix_literal_accumulator
// Feeds literals character by character in all four radixes: a directed set
// of corner cases, a back-pressure burst, then mostly well-formed random
// literals mixed with broken ones and noise. Both stream sides idle at
// random; rla_slice_checker predicts and compares every output slice.
// ----------------------------------------------------------------------------
module tb_radix_literal_accumulator
  import rla_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems    = 380;     // no new literal starts once this many are accepted
  localparam int HoldCycles  = 200;     // long sink stall during the burst
  localparam int DrainCycles = 8;       // extra wait once every slice has drained
  localparam int CycleLimit  = 300000;  // watchdog limit on the whole run

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic [23:0] s_axis_tdata   = '0;     // [7:0] character, [16:8] target_width
  logic        s_axis_tlast   = 1'b0;   // last_char
  logic [1:0]  s_axis_tuser   = '0;     // [1:0] base_sel
  logic        m_axis_tready  = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [71:0] m_axis_tdata_o;          // [63:0] value_word, [65:64] word_index
  wire         m_axis_tlast_o;          // last_word
  wire  [1:0]  m_axis_tuser_o;          // [1:0] status

  int fail_count;
  int pending;          // slices predicted but not yet seen
  int n_sent    = 0;    // accepted character requests
  int cycle_cnt = 0;
  bit calm      = 1'b0; // both sides skip their idle draws while set
  bit hold_out  = 1'b0; // asks the sink for one long stall

  radix_literal_accumulator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  rla_slice_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata),
    .s_tlast_i    (s_axis_tlast),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata_o),
    .m_tlast_i    (m_axis_tlast_o),
    .m_tuser_i    (m_axis_tuser_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $error("timeout after %0d cycles, %0d slices outstanding", cycle_cnt, pending);
    $display("** radix_literal_accumulator: FAILED **");
    $finish;
  end

  // Sink: random stall before every slice request, one long stall on demand.
  // tready only changes in steps where no other assignment to it is pending.
  initial begin : slice_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_out) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out = 1'b0;
      end
      gap = calm ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // One character request. With no gap drawn, tvalid simply stays high and
  // the next character follows in the cycle after acceptance.
  task automatic offer_char(input logic [7:0] ch, input base_e b, input logic [8:0] w,
                            input logic last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {7'd0, w, ch};
    s_axis_tuser  <= b;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
  endtask

  task automatic send_literal(input string text, input base_e b, input int w);
    for (int i = 0; i < text.len(); i++)
      offer_char(text[i], b, 9'(w), i == text.len() - 1);
  endtask

  // a legal digit of the radix; hex letters in either case
  function automatic logic [7:0] digit_char(input base_e b);
    int unsigned top_digit;
    int unsigned v;
    case (b)
      BASE_HEX: top_digit = 15;
      BASE_BIN: top_digit = 1;
      BASE_OCT: top_digit = 7;
      default:  top_digit = 9;
    endcase
    v = $urandom_range(0, top_digit);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  // Mostly well-formed literals with random digits, underscores and widths;
  // the rest carry one bad character, only underscores, or pure noise.
  task automatic send_random_literal();
    int unsigned kind;
    int unsigned len;
    int unsigned bad_pos;
    int unsigned pick;
    base_e       b;
    logic [8:0]  w;
    logic [8:0]  w_item;
    logic [7:0]  ch;
    kind = $urandom_range(0, 99);
    b    = base_e'($urandom_range(0, 3));
    pick = $urandom_range(0, 19);
    if (pick == 0)      w = 9'd0;
    else if (pick == 1) w = 9'($urandom_range(257, 511));
    else if (pick < 6)  w = 9'(64 * $urandom_range(1, 4));
    else                w = 9'($urandom_range(1, 256));
    // a few long literals overflow the full 256-bit accumulator
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    bad_pos = (kind >= 70 && kind < 85) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < len; i++) begin
      if (kind >= 95) begin
        ch = 8'($urandom_range(0, 255));
        b  = base_e'($urandom_range(0, 3));
      end else if (kind >= 85) begin
        ch = CharUnderscore;
      end else if (i == bad_pos) begin
        ch = 8'($urandom_range(0, 255));
      end else if ($urandom_range(0, 9) == 0) begin
        ch = CharUnderscore;
      end else begin
        // the radix may change mid-literal; each char is judged by its own
        if ($urandom_range(0, 19) == 0) b = base_e'($urandom_range(0, 3));
        ch = digit_char(b);
      end
      // only the width of the final char counts, so earlier ones may get junk
      w_item = (i == len - 1 || $urandom_range(0, 3) != 0) ? w : 9'($urandom);
      offer_char(ch, b, w_item, i == len - 1);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed corner cases ---
    send_literal("0", BASE_DEC, 0);            // width zero acts as width 1
    send_literal("9_9", BASE_DEC, 7);
    send_literal("fF_aA", BASE_HEX, 511);      // width saturates to four words
    send_literal("1_01", BASE_BIN, 2);         // masked down to two bits
    send_literal("78", BASE_OCT, 64);          // 8 is no octal digit
    send_literal("_", BASE_HEX, 8);            // no digits at all
    offer_char(8'hFF, BASE_DEC, 9'd65, 1'b1);  // bad and no digits: bad wins
    offer_char(8'h00, BASE_BIN, 9'd1, 1'b0);   // digit after a bad char is ignored
    offer_char("1", BASE_BIN, 9'd1, 1'b1);
    offer_char("B", BASE_HEX, 9'd128, 1'b0);   // radix switches per character,
    offer_char("1", BASE_BIN, 9'd128, 1'b0);   // and a trailing underscore ends it
    offer_char("_", BASE_DEC, 9'd256, 1'b1);
    send_literal("a", BASE_DEC, 64);
    send_literal("2", BASE_BIN, 65);

    // --- back-pressure: sink stalls long while two-char literals keep coming ---
    calm     = 1'b1;
    hold_out = 1'b1;
    for (int j = 0; j < 12; j++)
      offer_char(digit_char(BASE_HEX), BASE_HEX, 9'd200, j[0]);
    calm = 1'b0;
    // then go quiet until every slice has drained
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);

    // --- random literals, with calm stretches switched in and out ---
    while (n_sent < NumItems) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      send_random_literal();
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    // let the predictor see the final char, then wait out every slice
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("** radix_literal_accumulator: PASSED **");
    end else begin
      if (pending != 0) $error("%0d expected slices never arrived", pending);
      $display("** radix_literal_accumulator: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/rla_pkg.sv
sv/rla_word_emitter.sv
sv/radix_literal_accumulator.sv
tb/sv/rla_slice_checker.sv
tb/sv/tb_radix_literal_accumulator.sv
